FILE: hw/rtl/quadratic_form_gradient_core_defines.svh
// Assertion helpers shared by qfg_front and qfg_back.
// Each one expects clk and arst_n in the scope where it is used.
`ifndef QUADRATIC_FORM_GRADIENT_CORE_DEFINES_SVH
`define QUADRATIC_FORM_GRADIENT_CORE_DEFINES_SVH

// Same-cycle implication.
`define QFG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define QFG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/qfg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qfg_pkg;

	// Opcodes of the input word.
	localparam logic [1:0] OP_LOAD_H = 2'd0;
	localparam logic [1:0] OP_LOAD_C = 2'd1;
	localparam logic [1:0] OP_LOAD_X = 2'd2;
	localparam logic [1:0] OP_EVAL   = 2'd3;

	localparam int IDX_W   = 4;   // index fields
	localparam int VAL_W   = 32;  // Q16.16 operands
	localparam int LEN_W   = 5;   // vector_length register
	localparam int HX_W    = 52;  // sum of up to 16 Q.16 products
	localparam int GRAD_W  = 48;
	localparam int FORM_W  = 64;
	localparam int ACC_W   = 96;  // twice the form, Q.32
	localparam int PROD_W  = 64;
	localparam int HX_SPLIT = 26; // Hx is multiplied in two 26-bit halves

	localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [1:0]              op;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} qfg_item_t;

	// Tag that travels with an operand pair through read and multiply.
	typedef struct packed {
		logic             valid;
		logic             fm;      // form phase, else Hx phase
		logic             first;   // first column of a row
		logic             last_j;  // last column of a row
		logic [1:0]       k;       // form sub-step
		logic [IDX_W-1:0] idx;     // Hx row
	} qfg_tag_t;

	localparam logic [1:0] FM_CX   = 2'd0;
	localparam logic [1:0] FM_XHLO = 2'd1;
	localparam logic [1:0] FM_XHHI = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/qfg_front.sv
`timescale 1ns / 1ps
`default_nettype none
`include "quadratic_form_gradient_core_defines.svh"

module qfg_front #(
	parameter int MAX_VARS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        opcode,
	input  wire logic [qfg_pkg::IDX_W-1:0]         row_index,
	input  wire logic [qfg_pkg::IDX_W-1:0]         col_index,
	input  wire logic signed [qfg_pkg::VAL_W-1:0]  value,
	output logic                                   q_valid,
	output qfg_pkg::qfg_item_t                     q_item,
	input  wire logic                              q_pop
);
	import qfg_pkg::*;

	qfg_item_t          fifo_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               accept;
	logic               keep;
	logic               push;
	logic               pop;
	logic               row_ok;
	logic               col_ok;

	assign in_stall = (count_q == QCNT_W'(QDEPTH));
	assign accept   = in_valid && !in_stall;

	// Out-of-range loads are dropped here.
	assign row_ok = (32'(row_index) < 32'(MAX_VARS));
	assign col_ok = (32'(col_index) < 32'(MAX_VARS));

	always_comb begin
		unique case (opcode)
			OP_LOAD_H: keep = row_ok && col_ok;
			OP_LOAD_C, OP_LOAD_X: keep = row_ok;
			OP_EVAL: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign push    = accept && keep;
	assign q_valid = (count_q != '0);
	assign pop     = q_pop && q_valid;
	assign q_item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{op: opcode, row: row_index, col: col_index, value: value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`QFG_ASSERT_NXT(a_fill_up, push && !pop, count_q == $past(count_q) + QCNT_W'(1), "queue count lost a push")
	`QFG_ASSERT_IMP(a_fill_max, 1'b1, count_q <= QCNT_W'(QDEPTH), "queue overfilled")

endmodule

`default_nettype wire

FILE: hw/rtl/qfg_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "quadratic_form_gradient_core_defines.svh"

module qfg_back #(
	parameter int MAX_VARS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [qfg_pkg::IDX_W-1:0]           n_last,
	input  wire logic                                q_valid,
	input  wire qfg_pkg::qfg_item_t                  q_item,
	output logic                                     q_pop,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [qfg_pkg::IDX_W-1:0]                grad_index,
	output logic signed [qfg_pkg::GRAD_W-1:0]        grad_value,
	output logic signed [qfg_pkg::FORM_W-1:0]        form_value,
	output logic                                     last
);
	import qfg_pkg::*;

	localparam int IW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
	localparam int HD    = MAX_VARS * MAX_VARS;
	localparam int AW    = (HD > 1) ? $clog2(HD) : 1;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_HX       = 3'd1;
	localparam logic [2:0] ST_HX_DRAIN = 3'd2;
	localparam logic [2:0] ST_FM       = 3'd3;
	localparam logic [2:0] ST_FM_DRAIN = 3'd4;
	localparam logic [2:0] ST_OUT_RD   = 3'd5;
	localparam logic [2:0] ST_OUT_WR   = 3'd6;

	// stores
	logic signed [VAL_W-1:0] h_mem  [HD];
	logic signed [VAL_W-1:0] x_mem  [MAX_VARS];
	logic signed [VAL_W-1:0] c_mem  [MAX_VARS];
	logic signed [HX_W-1:0]  hx_mem [MAX_VARS];

	logic [2:0]       state_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [1:0]       k_q;

	qfg_tag_t issue;
	qfg_tag_t tag_s1;
	qfg_tag_t tag_s2;

	logic [AW-1:0] h_raddr;
	logic [IW-1:0] x_raddr;
	logic [IW-1:0] cv_raddr;
	logic [AW-1:0] h_waddr;
	logic [IW-1:0] v_waddr;

	logic signed [VAL_W-1:0]  h_rd_s1;
	logic signed [VAL_W-1:0]  x_rd_s1;
	logic signed [VAL_W-1:0]  c_rd_s1;
	logic signed [HX_W-1:0]   hx_rd_s1;

	logic signed [VAL_W-1:0]  mul_a;
	logic signed [VAL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [HX_W-1:0]   hx_acc_q;
	logic signed [HX_W-1:0]   hx_term;
	logic signed [HX_W-1:0]   hx_sum;
	logic signed [ACC_W-1:0]  form_acc_q;
	logic signed [ACC_W-1:0]  prod_wide;
	logic signed [ACC_W-1:0]  fm_term;

	logic                     ld;
	logic                     eval_start;
	logic                     pipe_empty;
	logic                     out_free;
	logic                     out_load;

	logic signed [GRAD_W:0]   dummy_unused_guard;
	logic signed [HX_W:0]     g_sum;
	logic signed [GRAD_W-1:0] g_sat;
	logic signed [ACC_W-1:0]  f_shift;
	logic signed [FORM_W-1:0] f_sat;

	logic                     out_valid_q;
	logic [IDX_W-1:0]         out_idx_q;
	logic signed [GRAD_W-1:0] out_grad_q;
	logic signed [FORM_W-1:0] out_form_q;
	logic                     out_last_q;

	// ---------------- control ----------------
	assign ld         = (state_q == ST_IDLE) && q_valid;
	assign q_pop      = ld;
	assign eval_start = ld && (q_item.op == OP_EVAL);
	assign pipe_empty = !tag_s1.valid && !tag_s2.valid;
	assign out_free   = !out_valid_q || !out_stall;
	assign out_load   = (state_q == ST_OUT_WR) && out_free;

	always_comb begin
		issue = '0;
		unique case (state_q)
			ST_HX: begin
				issue.valid  = 1'b1;
				issue.first  = (j_q == '0);
				issue.last_j = (j_q == n_last);
				issue.idx    = i_q;
			end
			ST_FM: begin
				issue.valid = 1'b1;
				issue.fm    = 1'b1;
				issue.k     = k_q;
			end
			ST_IDLE, ST_HX_DRAIN, ST_FM_DRAIN, ST_OUT_RD, ST_OUT_WR: begin
				issue = '0;
			end
			default: issue = '0;
		endcase
	end

	assign h_raddr  = AW'(32'(i_q) * MAX_VARS + 32'(j_q));
	assign x_raddr  = IW'(j_q);
	assign cv_raddr = ((state_q == ST_OUT_RD) || (state_q == ST_OUT_WR)) ? IW'(i_q) : IW'(j_q);
	assign h_waddr  = AW'(32'(q_item.row) * MAX_VARS + 32'(q_item.col));
	assign v_waddr  = IW'(q_item.row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= FM_CX;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (eval_start) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_HX;
					end
				end
				ST_HX: begin
					if (j_q == n_last) begin
						j_q <= '0;
						if (i_q == n_last) begin
							state_q <= ST_HX_DRAIN;
						end else begin
							i_q <= i_q + IDX_W'(1);
						end
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_HX_DRAIN: begin
					if (pipe_empty) begin
						j_q     <= '0;
						k_q     <= FM_CX;
						state_q <= ST_FM;
					end
				end
				ST_FM: begin
					if (k_q == FM_XHHI) begin
						k_q <= FM_CX;
						if (j_q == n_last) begin
							state_q <= ST_FM_DRAIN;
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_FM_DRAIN: begin
					if (pipe_empty) begin
						i_q     <= '0;
						state_q <= ST_OUT_RD;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_WR;
				end
				ST_OUT_WR: begin
					if (out_free) begin
						if (i_q == n_last) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- stores ----------------
	always_ff @(posedge clk) begin
		if (ld && (q_item.op == OP_LOAD_H)) begin
			h_mem[h_waddr] <= q_item.value;
		end
		h_rd_s1 <= h_mem[h_raddr];
	end

	always_ff @(posedge clk) begin
		if (ld && (q_item.op == OP_LOAD_X)) begin
			x_mem[v_waddr] <= q_item.value;
		end
		x_rd_s1 <= x_mem[x_raddr];
	end

	always_ff @(posedge clk) begin
		if (ld && (q_item.op == OP_LOAD_C)) begin
			c_mem[v_waddr] <= q_item.value;
		end
		c_rd_s1 <= c_mem[cv_raddr];
	end

	always_ff @(posedge clk) begin
		if (tag_s2.valid && !tag_s2.fm && tag_s2.last_j) begin
			hx_mem[IW'(tag_s2.idx)] <= hx_sum;
		end
		hx_rd_s1 <= hx_mem[cv_raddr];
	end

	// ---------------- multiply / accumulate ----------------
	always_comb begin
		mul_a = x_rd_s1;
		mul_b = x_rd_s1;
		if (!tag_s1.fm) begin
			mul_a = h_rd_s1;
		end else begin
			case (tag_s1.k)
				FM_CX:   mul_b = c_rd_s1;
				FM_XHLO: mul_b = {{(VAL_W - HX_SPLIT){1'b0}}, hx_rd_s1[HX_SPLIT-1:0]};
				default: mul_b = {{(VAL_W - (HX_W - HX_SPLIT)){hx_rd_s1[HX_W-1]}},
					hx_rd_s1[HX_W-1:HX_SPLIT]};
			endcase
		end
	end

	assign hx_term   = HX_W'(prod_s2 >>> 16);
	assign hx_sum    = (tag_s2.first ? HX_W'(0) : hx_acc_q) + hx_term;
	assign prod_wide = ACC_W'(prod_s2);

	always_comb begin
		case (tag_s2.k)
			FM_CX:   fm_term = prod_wide <<< 1;
			FM_XHLO: fm_term = prod_wide;
			default: fm_term = prod_wide <<< HX_SPLIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= issue;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * mul_b;
		if (tag_s2.valid && !tag_s2.fm) begin
			hx_acc_q <= hx_sum;
		end
		if (eval_start) begin
			form_acc_q <= '0;
		end else if (tag_s2.valid && tag_s2.fm) begin
			form_acc_q <= form_acc_q + fm_term;
		end
	end

	// ---------------- result ----------------
	assign g_sum = {hx_rd_s1[HX_W-1], hx_rd_s1} + (HX_W+1)'(c_rd_s1);
	assign dummy_unused_guard = g_sum[GRAD_W:0];

	always_comb begin
		if (g_sum[HX_W:GRAD_W-1] == '0 || g_sum[HX_W:GRAD_W-1] == '1) begin
			g_sat = dummy_unused_guard[GRAD_W-1:0];
		end else if (g_sum[HX_W]) begin
			g_sat = {1'b1, {(GRAD_W-1){1'b0}}};
		end else begin
			g_sat = {1'b0, {(GRAD_W-1){1'b1}}};
		end
	end

	assign f_shift = form_acc_q >>> 17;

	always_comb begin
		if (f_shift[ACC_W-1:FORM_W-1] == '0 || f_shift[ACC_W-1:FORM_W-1] == '1) begin
			f_sat = f_shift[FORM_W-1:0];
		end else if (f_shift[ACC_W-1]) begin
			f_sat = {1'b1, {(FORM_W-1){1'b0}}};
		end else begin
			f_sat = {1'b0, {(FORM_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= i_q;
			out_grad_q <= g_sat;
			out_last_q <= (i_q == n_last);
			out_form_q <= (i_q == n_last) ? f_sat : FORM_W'(0);
		end
	end

	assign out_valid  = out_valid_q;
	assign grad_index = out_idx_q;
	assign grad_value = out_grad_q;
	assign form_value = out_form_q;
	assign last       = out_last_q;

	`QFG_ASSERT_IMP(a_out_drained, state_q == ST_OUT_RD || state_q == ST_OUT_WR, pipe_empty, "results read before the pipeline drained")
	`QFG_ASSERT_IMP(a_last_idx, out_valid_q && out_last_q, out_idx_q == n_last, "last word at wrong index")
	`QFG_ASSERT_IMP(a_tag_phase, tag_s2.valid, state_q == ST_HX || state_q == ST_HX_DRAIN || state_q == ST_FM || state_q == ST_FM_DRAIN, "multiplier busy outside an evaluation")
	`QFG_ASSERT_NXT(a_eval_runs, eval_start, state_q == ST_HX && !q_pop, "evaluate word did not start the sequencer")

endmodule

`default_nettype wire

FILE: hw/rtl/quadratic_form_gradient_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Quadratic form value and gradient engine. Words on the input channel load
// the matrix H, the linear term c and the point x one element at a time
// (opcode 0, 1, 2) or ask for an evaluation (opcode 3). An evaluation gives
// n words on the output channel, gradient element g[k] = (Hx)[k] + c[k] in
// index order, and the last one also carries f = c'x + 0.5*x'Hx; form_value
// is zero on the other words. Inputs are signed Q16.16; g is Q32.16
// saturated to 48 bits, f is Q48.16 saturated to 64 bits. Each product
// H[i][j]*x[j] is floored to Q.16 before it is summed into Hx. n is
// vector_length, with 0 read as 1 and large values clipped to the smaller of
// MAX_VARS and 16; write it only while the core is idle. Loads whose index is
// MAX_VARS or more are dropped, and a store entry must be loaded before an
// evaluation reads it. Input words pass through a four-word queue, so loads
// are taken one per cycle while an evaluation is running until that queue
// is full. While idle, the execution unit pops each load from the queue and
// writes it into its store. An evaluation uses one shared 32x32 multiplier:
// one H*x product a cycle, then three products per element for the form
// value (c*x and x times each half of Hx). The output stage reads a gradient
// element through the single read port of each store, then registers it.

module quadratic_form_gradient_core #(
	parameter int MAX_VARS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	// configuration: vector_length
	input  wire logic                                cfg_we,
	input  wire logic [qfg_pkg::LEN_W-1:0]           cfg_wdata,

	// input word
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          opcode,
	input  wire logic [qfg_pkg::IDX_W-1:0]           row_index,
	input  wire logic [qfg_pkg::IDX_W-1:0]           col_index,
	input  wire logic signed [qfg_pkg::VAL_W-1:0]    value,

	// result word
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [qfg_pkg::IDX_W-1:0]                grad_index,
	output logic signed [qfg_pkg::GRAD_W-1:0]        grad_value,
	output logic signed [qfg_pkg::FORM_W-1:0]        form_value,
	output logic                                     last
);
	import qfg_pkg::*;

	// largest usable n
	localparam int CAP = (MAX_VARS < 16) ? MAX_VARS : 16;

	logic [LEN_W-1:0] vector_length_q;
	logic [LEN_W-1:0] n_eff;
	logic [IDX_W-1:0] n_last;

	logic      q_valid;
	qfg_item_t q_item;
	logic      q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_length_q <= LEN_RESET;
		end else if (cfg_we) begin
			vector_length_q <= cfg_wdata;
		end
	end

	// zero counts as one, anything past the built size is clipped
	always_comb begin
		if (vector_length_q == '0) begin
			n_eff = LEN_W'(1);
		end else if (vector_length_q > LEN_W'(CAP)) begin
			n_eff = LEN_W'(CAP);
		end else begin
			n_eff = vector_length_q;
		end
	end

	assign n_last = IDX_W'(n_eff - LEN_W'(1));

	// front: accept, filter out-of-range loads, queue
	qfg_front #(
		.MAX_VARS (MAX_VARS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.row_index (row_index),
		.col_index (col_index),
		.value     (value),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	// back: stores, multiply-accumulate sequencer, output register
	qfg_back #(
		.MAX_VARS (MAX_VARS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.n_last     (n_last),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.grad_index (grad_index),
		.grad_value (grad_value),
		.form_value (form_value),
		.last       (last)
	);

endmodule

`default_nettype wire

FILE: sim/form_gradient_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the quadratic form core, keeps its own copy of
// the H, c and x stores and of vector_length, and works out the gradient
// words that each evaluate word must produce.
module form_gradient_checker
	import qfg_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [LEN_W-1:0]         cfg_wdata,
	input  wire logic                     in_valid,
	input  wire logic                     in_stall,
	input  wire logic [1:0]               opcode,
	input  wire logic [IDX_W-1:0]         row_index,
	input  wire logic [IDX_W-1:0]         col_index,
	input  wire logic signed [VAL_W-1:0]  value,
	input  wire logic                     out_valid,
	input  wire logic                     out_stall,
	input  wire logic [IDX_W-1:0]         grad_index,
	input  wire logic signed [GRAD_W-1:0] grad_value,
	input  wire logic signed [FORM_W-1:0] form_value,
	input  wire logic                     last,
	output logic [31:0]                   mismatch_count,
	output logic [31:0]                   words_due
);

	localparam logic signed [63:0]  GRAD_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0]  GRAD_LO = -64'sh0000_8000_0000_0000;
	localparam logic signed [127:0] FORM_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [127:0] FORM_LO = -128'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic signed [GRAD_W-1:0] grad;
		logic signed [FORM_W-1:0] form;
		logic                    last;
	} grad_word_t;

	logic signed [VAL_W-1:0] h_mem [16][16];
	logic signed [VAL_W-1:0] c_mem [16];
	logic signed [VAL_W-1:0] x_mem [16];
	logic [LEN_W-1:0]        length_reg;
	grad_word_t              gradient_words_due [$];
	grad_word_t              seen;

	initial mismatch_count = 0;
	initial words_due = 0;

	// g = Hx + c per element, each product floored to Q.16 before the row sum;
	// twice the form summed exactly, then floored by 2^17 and clipped.
	function automatic void compute_gradient_words();
		int n, i, j;
		logic signed [63:0]  hx [16];
		logic signed [63:0]  prod, row_sum, grad;
		logic signed [127:0] twice_form, term, form_q;
		grad_word_t          w;
		n = (length_reg == 0) ? 1 : (length_reg > 16) ? 16 : int'(length_reg);
		for (i = 0; i < n; i++) begin
			row_sum = 0;
			for (j = 0; j < n; j++) begin
				prod = h_mem[i][j] * x_mem[j];
				row_sum = row_sum + (prod >>> 16);
			end
			hx[i] = row_sum;
		end
		twice_form = 0;
		for (j = 0; j < n; j++) begin
			term = c_mem[j];
			term = term * x_mem[j];
			twice_form = twice_form + (term <<< 1);
			term = x_mem[j];
			term = term * hx[j];
			twice_form = twice_form + term;
		end
		form_q = twice_form >>> 17;
		if (form_q > FORM_HI)
			form_q = FORM_HI;
		else if (form_q < FORM_LO)
			form_q = FORM_LO;
		for (i = 0; i < n; i++) begin
			grad = hx[i] + c_mem[i];
			if (grad > GRAD_HI)
				grad = GRAD_HI;
			else if (grad < GRAD_LO)
				grad = GRAD_LO;
			w.idx = i[IDX_W-1:0];
			w.grad = grad[GRAD_W-1:0];
			w.form = (i == n - 1) ? form_q[FORM_W-1:0] : '0;
			w.last = (i == n - 1);
			gradient_words_due.push_back(w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_reg = LEN_RESET;
			gradient_words_due.delete();
		end else begin
			// results first: a word leaving now never belongs to an
			// evaluate word taken at this same edge
			if (out_valid && !out_stall) begin
				if (gradient_words_due.size() == 0) begin
					$error("result word with nothing due: index %0d", grad_index);
					mismatch_count++;
				end else begin
					seen = gradient_words_due.pop_front();
					if (grad_index !== seen.idx) begin
						$error("grad_index: expected %0d, got %0d", seen.idx, grad_index);
						mismatch_count++;
					end
					if (grad_value !== seen.grad) begin
						$error("grad_value: expected %0d, got %0d",
							$signed(seen.grad), grad_value);
						mismatch_count++;
					end
					if (form_value !== seen.form) begin
						$error("form_value: expected %0d, got %0d",
							$signed(seen.form), form_value);
						mismatch_count++;
					end
					if (last !== seen.last) begin
						$error("last: expected %0d, got %0d", seen.last, last);
						mismatch_count++;
					end
				end
			end
			if (cfg_we)
				length_reg = cfg_wdata;
			if (in_valid && !in_stall) begin
				case (opcode)
					OP_LOAD_H: h_mem[row_index][col_index] = value;
					OP_LOAD_C: c_mem[row_index] = value;
					OP_LOAD_X: x_mem[row_index] = value;
					OP_EVAL:   compute_gradient_words();
					default: ;
				endcase
			end
		end
		words_due = gradient_words_due.size();
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for quadratic_form_gradient_core. The checker beside
// the core does all prediction and comparison; this module only makes words,
// stalls the result side and decides the outcome.
module testbench;
	import qfg_pkg::*;

	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam int          DRAIN_CYCLES = 40;   // queue plus one load per slot
	localparam int          HOLD_CYCLES = 300;   // long receiver hold-off
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [LEN_W-1:0]         cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               opcode = OP_LOAD_H;
	logic [IDX_W-1:0]         row_index = '0;
	logic [IDX_W-1:0]         col_index = '0;
	logic signed [VAL_W-1:0]  value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [IDX_W-1:0]         grad_index;
	logic signed [GRAD_W-1:0] grad_value;
	logic signed [FORM_W-1:0] form_value;
	logic                     last;

	logic [31:0] mismatch_count;
	logic [31:0] words_due;

	// bookkeeping of the stimulus side
	bit          h_written [16][16];
	bit          c_written [16];
	bit          x_written [16];
	int          active_len = 16;     // effective n after the last length write
	int          words_sent = 0;
	int          evals_sent = 0;
	int          results_seen = 0;
	int          cycle_count = 0;
	logic        pressure_armed = 1'b0;
	int          hold_left = 0;
	bit          pressure_done = 0;

	always #2 clk = ~clk;

	quadratic_form_gradient_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.row_index  (row_index),
		.col_index  (col_index),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.grad_index (grad_index),
		.grad_value (grad_value),
		.form_value (form_value),
		.last       (last)
	);

	form_gradient_checker grad_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.row_index      (row_index),
		.col_index      (col_index),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.grad_index     (grad_index),
		.grad_value     (grad_value),
		.form_value     (form_value),
		.last           (last),
		.mismatch_count (mismatch_count),
		.words_due      (words_due)
	);

	// Hang guard. Sized far above the slowest legal run: ~600 words, each
	// evaluation at most 16 result words, plus receiver stalls.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycle_count, words_due);
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			results_seen++;
	end

	// Result side. One long hold-off once the pressure point is armed and a
	// result shows up; a clean stretch with no stalls between 30 and 90
	// results; otherwise a stall in about a third of the cycles.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (pressure_armed && !pressure_done && out_valid) begin
			pressure_done = 1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (results_seen >= 30 && results_seen < 90) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 32);
		end
	end

	function automatic int clip_length(input int v);
		return (v == 0) ? 1 : (v > 16) ? 16 : v;
	endfunction

	// Mix of corner values, tiny values, mid-size values and full-range noise.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return ($urandom_range(2) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(1));
			3, 4: return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
			default: return $urandom();
		endcase
	endfunction

	// Offers one word from a falling edge and returns at the falling edge after
	// it was taken, with valid still high so a following word needs no drop.
	// The sender skips gaps while words 60..139 go out.
	task automatic send_word(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
			input logic [31:0] v);
		if ((words_sent < 60 || words_sent >= 140) && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		row_index <= r;
		col_index <= c;
		value <= v;
		case (op)
			OP_LOAD_H: h_written[r][c] = 1;
			OP_LOAD_C: c_written[r] = 1;
			OP_LOAD_X: x_written[r] = 1;
			default: evals_sent++;
		endcase
		words_sent++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_eval();
		send_word(OP_EVAL, 4'($urandom_range(15)), 4'($urandom_range(15)), $urandom());
	endtask

	// Drop valid, let every due result come out, then give trailing loads time
	// to leave the queue so the length register is written while idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (words_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		active_len = clip_length(int'(v));
	endtask

	// Loads every entry that an evaluation at the current n reads and that
	// was never written, so no evaluation touches an undefined store entry.
	task automatic fill_missing();
		for (int i = 0; i < active_len; i++)
			for (int j = 0; j < active_len; j++)
				if (!h_written[i][j])
					send_word(OP_LOAD_H, 4'(i), 4'(j), pick_value());
		for (int i = 0; i < active_len; i++) begin
			if (!c_written[i])
				send_word(OP_LOAD_C, 4'(i), 4'($urandom_range(15)), pick_value());
			if (!x_written[i])
				send_word(OP_LOAD_X, 4'(i), 4'($urandom_range(15)), pick_value());
		end
	endtask

	// One length setting: fill, then random loads with evaluations mixed in.
	// Most loads stay inside the live n; some hit any index.
	task automatic run_length_phase(input logic [LEN_W-1:0] len, input int n_words);
		logic [1:0] op;
		logic [3:0] r;
		logic [3:0] c;
		write_length(len);
		fill_missing();
		repeat (n_words) begin
			if ($urandom_range(99) < 25) begin
				send_eval();
			end else begin
				op = 2'($urandom_range(2));
				r = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
					: 4'($urandom_range(active_len - 1));
				c = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
					: 4'($urandom_range(active_len - 1));
				send_word(op, r, c, pick_value());
			end
		end
		send_eval();
	endtask

	// Full-size case with a length above the built size (31 clips to 16).
	// Rows 0..7 of H hold the most negative value, rows 8..15 the most
	// positive one, so with x nonzero only in one half the form runs off
	// either end of 64 bits and every gradient element clips at 48 bits.
	task automatic run_full_size_phase();
		write_length(5'd31);
		for (int i = 0; i < 16; i++)
			for (int j = 0; j < 16; j++)
				send_word(OP_LOAD_H, 4'(i), 4'(j), (i < 8) ? Q_MIN : Q_MAX);
		for (int i = 0; i < 16; i++) begin
			send_word(OP_LOAD_C, 4'(i), 4'($urandom_range(15)), pick_value());
			send_word(OP_LOAD_X, 4'(i), 4'($urandom_range(15)), (i < 8) ? Q_MIN : 32'd0);
		end
		send_eval();
		// the x reload below queues up behind this evaluation while the
		// receiver holds off, so the input queue fills and stalls
		pressure_armed <= 1'b1;
		for (int i = 0; i < 16; i++)
			send_word(OP_LOAD_X, 4'(i), 4'($urandom_range(15)), (i < 8) ? 32'd0 : Q_MIN);
		send_eval();
		for (int i = 0; i < 16; i++)
			send_word(OP_LOAD_X, 4'(i), 4'($urandom_range(15)),
				32'($urandom_range(32'h0004_0000)) - 32'h0002_0000);
		send_eval();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, n = 2. First all operands at the negative corner: Hx is
		// +2^47 and pushing c to its max clips the gradient high.
		write_length(5'd2);
		send_word(OP_LOAD_H, 4'd0, 4'd0, Q_MIN);
		send_word(OP_LOAD_H, 4'd0, 4'd1, Q_MIN);
		send_word(OP_LOAD_H, 4'd1, 4'd0, Q_MIN);
		send_word(OP_LOAD_H, 4'd1, 4'd1, Q_MIN);
		send_word(OP_LOAD_X, 4'd0, 4'd15, Q_MIN);
		send_word(OP_LOAD_X, 4'd1, 4'd0, Q_MIN);
		send_word(OP_LOAD_C, 4'd0, 4'd7, Q_MAX);
		send_word(OP_LOAD_C, 4'd1, 4'd8, 32'h0001_0000);
		send_eval();
		// x at the positive corner and c at its minimum: element 0 clips low,
		// element 1 lands just inside the range
		send_word(OP_LOAD_X, 4'd0, 4'd3, Q_MAX);
		send_word(OP_LOAD_X, 4'd1, 4'd12, Q_MAX);
		send_word(OP_LOAD_C, 4'd0, 4'd5, Q_MIN);
		send_word(OP_LOAD_C, 4'd1, 4'd10, 32'hFFFF_FFFF);
		send_eval();
		// tiny products: floor toward minus infinity on negative ones
		send_word(OP_LOAD_H, 4'd0, 4'd1, 32'd0);
		send_word(OP_LOAD_H, 4'd1, 4'd0, 32'd1);
		send_word(OP_LOAD_X, 4'd0, 4'd9, 32'hFFFF_FFFF);
		send_word(OP_LOAD_X, 4'd1, 4'd6, 32'h0001_8000);
		send_word(OP_LOAD_C, 4'd0, 4'd11, 32'd0);
		send_eval();

		// Random part across lengths: small, zero (reads as one), full size
		// clipped from 31, exactly 16, one, and a mid value.
		run_length_phase(5'd3, 20);
		run_length_phase(5'd0, 20);
		run_length_phase(5'd5, 25);
		run_full_size_phase();
		run_length_phase(5'd16, 20);
		run_length_phase(5'd1, 15);
		run_length_phase(5'd9, 25);

		settle();
		$display("covered %0d input words, %0d evaluations, %0d gradient words", words_sent,
			evals_sent, results_seen);
		$display("lengths 0 to 31, corner and clipping patterns, one long result hold-off");
		if (mismatch_count == 0 && words_due == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
